// File: rtl/core/qamm_pkg.sv
// ----------------------------------------------------------------------------
// qamm_pkg
// Shared types and constants of the arming and X-frame motor mixer unit.
// ----------------------------------------------------------------------------
package qamm_pkg;

    localparam int WIDTH_W  = 12;
    localparam int CORR_W   = 11;
    localparam int PULSE_W  = 12;
    localparam int MIX_W    = 14;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 12;
    localparam int IN_TDW   = 88;
    localparam int OUT_TDW  = 56;

    localparam logic [CFG_AW-1:0] CFG_THR_LIMIT    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_STICK_LOW    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_STICK_HIGH   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_MIN_SPIN     = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_MAX_PULSE    = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_OFF_PULSE    = 3'd5;

    localparam logic [10:0] RST_THR_LIMIT    = 11'd1800;
    localparam logic [10:0] RST_STICK_LOW    = 11'd1050;
    localparam logic [11:0] RST_STICK_HIGH   = 12'd1950;
    localparam logic [10:0] RST_MIN_SPIN     = 11'd1100;
    localparam logic [11:0] RST_MAX_PULSE    = 12'd2000;
    localparam logic [10:0] RST_OFF_PULSE    = 11'd1000;

    typedef struct packed {
        logic [10:0] thr_limit;
        logic [10:0] stick_low;
        logic [11:0] stick_high;
        logic [10:0] min_spin;
        logic [11:0] max_pulse;
        logic [10:0] off_pulse;
    } t_cfg;

    // last declared field in the lowest bits
    typedef struct packed {
        logic [6:0]               pad;
        logic signed [CORR_W-1:0] yaw_corr;
        logic signed [CORR_W-1:0] pitch_corr;
        logic signed [CORR_W-1:0] roll_corr;
        logic [WIDTH_W-1:0]       yaw_w;
        logic [WIDTH_W-1:0]       pitch_w;
        logic [WIDTH_W-1:0]       roll_w;
        logic [WIDTH_W-1:0]       throttle_w;
    } t_in_item;

    typedef struct packed {
        logic [4:0]         pad;
        logic               ctl_reset;
        logic               recal;
        logic               armed_now;
        logic [PULSE_W-1:0] front_left;
        logic [PULSE_W-1:0] back_left;
        logic [PULSE_W-1:0] back_right;
        logic [PULSE_W-1:0] front_right;
    } t_out_item;

    typedef struct packed {
        logic armed_next;
        logic recal;
        logic ctl_reset;
        logic spin;
    } t_arm_status;

endpackage

// File: rtl/core/qamm_cfg_regs.sv
// ----------------------------------------------------------------------------
// qamm_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module qamm_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [qamm_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [qamm_pkg::CFG_DW-1:0] i_cfg_wdata,
    output qamm_pkg::t_cfg              o_cfg
);
    import qamm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr_limit    <= RST_THR_LIMIT;
            r_cfg.stick_low    <= RST_STICK_LOW;
            r_cfg.stick_high   <= RST_STICK_HIGH;
            r_cfg.min_spin     <= RST_MIN_SPIN;
            r_cfg.max_pulse    <= RST_MAX_PULSE;
            r_cfg.off_pulse    <= RST_OFF_PULSE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_THR_LIMIT:    r_cfg.thr_limit    <= i_cfg_wdata[10:0];
                CFG_STICK_LOW:    r_cfg.stick_low    <= i_cfg_wdata[10:0];
                CFG_STICK_HIGH:   r_cfg.stick_high   <= i_cfg_wdata;
                CFG_MIN_SPIN:     r_cfg.min_spin     <= i_cfg_wdata[10:0];
                CFG_MAX_PULSE:    r_cfg.max_pulse    <= i_cfg_wdata;
                CFG_OFF_PULSE:    r_cfg.off_pulse    <= i_cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/qamm_arming.sv
// ----------------------------------------------------------------------------
// qamm_arming
// Stick gesture decode: arm, arm with recalibration, disarm.
// ----------------------------------------------------------------------------
module qamm_arming (
    input  logic                         i_armed,
    input  logic [qamm_pkg::WIDTH_W-1:0] i_throttle_w,
    input  logic [qamm_pkg::WIDTH_W-1:0] i_roll_w,
    input  logic [qamm_pkg::WIDTH_W-1:0] i_pitch_w,
    input  logic [qamm_pkg::WIDTH_W-1:0] i_yaw_w,
    input  logic [10:0]                  i_stick_low,
    input  logic [11:0]                  i_stick_high,
    output qamm_pkg::t_arm_status        o_status
);
    import qamm_pkg::*;

    logic thr_lo, rol_lo, rol_hi, pit_lo, yaw_lo, yaw_hi;
    logic arm_recal, armed_a, arm_plain, armed_b, disarm, armed_c;

    always_comb begin
        thr_lo = i_throttle_w < {1'b0, i_stick_low};
        rol_lo = i_roll_w     < {1'b0, i_stick_low};
        pit_lo = i_pitch_w    < {1'b0, i_stick_low};
        yaw_lo = i_yaw_w      < {1'b0, i_stick_low};
        rol_hi = i_roll_w     > i_stick_high;
        yaw_hi = i_yaw_w      > i_stick_high;

        arm_recal = !i_armed && thr_lo && rol_lo && pit_lo && yaw_hi;
        armed_a   = i_armed || arm_recal;
        arm_plain = !armed_a && thr_lo && rol_hi && pit_lo && yaw_hi;
        armed_b   = armed_a || arm_plain;
        disarm    = armed_b && thr_lo && rol_hi && pit_lo && yaw_lo;
        armed_c   = armed_b && !disarm;

        o_status.armed_next = armed_c;
        o_status.recal      = arm_recal;
        o_status.ctl_reset  = armed_c && thr_lo;
        o_status.spin       = armed_c && !thr_lo;
    end

endmodule

// File: rtl/core/qamm_mixer.sv
// ----------------------------------------------------------------------------
// qamm_mixer
// Throttle cap, X-frame mix and clamp of the four motor pulses, or the off pulse when not spinning.
// ----------------------------------------------------------------------------
module qamm_mixer (
    input  logic                                i_spin,
    input  logic [qamm_pkg::WIDTH_W-1:0]        i_throttle_w,
    input  logic signed [qamm_pkg::CORR_W-1:0]  i_roll_corr,
    input  logic signed [qamm_pkg::CORR_W-1:0]  i_pitch_corr,
    input  logic signed [qamm_pkg::CORR_W-1:0]  i_yaw_corr,
    input  qamm_pkg::t_cfg                      i_cfg,
    output logic [qamm_pkg::PULSE_W-1:0]        o_front_right,
    output logic [qamm_pkg::PULSE_W-1:0]        o_back_right,
    output logic [qamm_pkg::PULSE_W-1:0]        o_back_left,
    output logic [qamm_pkg::PULSE_W-1:0]        o_front_left
);
    import qamm_pkg::*;

    function automatic logic [PULSE_W-1:0] clamp_pulse(
        input logic signed [MIX_W-1:0] v,
        input logic [10:0]             lo,
        input logic [11:0]             hi
    );
        logic signed [MIX_W-1:0] x;
        begin
            x = v;
            if (x < $signed({3'b000, lo})) x = $signed({3'b000, lo});
            if (x > $signed({2'b00, hi}))  x = $signed({2'b00, hi});
            return x[PULSE_W-1:0];
        end
    endfunction

    logic [10:0]             thr_cap;
    logic signed [MIX_W-1:0] t, cr, cp, cy;
    logic signed [MIX_W-1:0] mix_fr, mix_br, mix_bl, mix_fl;
    logic [PULSE_W-1:0]      off;

    always_comb begin
        thr_cap = (i_throttle_w > {1'b0, i_cfg.thr_limit}) ? i_cfg.thr_limit
                                                           : i_throttle_w[10:0];
        t  = $signed({3'b000, thr_cap});
        cr = {{(MIX_W-CORR_W){i_roll_corr[CORR_W-1]}},  i_roll_corr};
        cp = {{(MIX_W-CORR_W){i_pitch_corr[CORR_W-1]}}, i_pitch_corr};
        cy = {{(MIX_W-CORR_W){i_yaw_corr[CORR_W-1]}},   i_yaw_corr};

        mix_fr = t + cr + cp - cy;
        mix_br = t + cr - cp + cy;
        mix_bl = t - cr - cp - cy;
        mix_fl = t - cr + cp + cy;

        off = {1'b0, i_cfg.off_pulse};
        if (i_spin) begin
            o_front_right = clamp_pulse(mix_fr, i_cfg.min_spin, i_cfg.max_pulse);
            o_back_right  = clamp_pulse(mix_br, i_cfg.min_spin, i_cfg.max_pulse);
            o_back_left   = clamp_pulse(mix_bl, i_cfg.min_spin, i_cfg.max_pulse);
            o_front_left  = clamp_pulse(mix_fl, i_cfg.min_spin, i_cfg.max_pulse);
        end else begin
            o_front_right = off;
            o_back_right  = off;
            o_back_left   = off;
            o_front_left  = off;
        end
    end

endmodule

// File: rtl/core/quad_arming_and_motor_mixer_unit.sv
// ----------------------------------------------------------------------------
// quad_arming_and_motor_mixer_unit
// Stick-gesture arming and X-frame motor mixer for a quadcopter.
// ----------------------------------------------------------------------------
// One request per control tick carries the four receiver widths and three
// attitude corrections; one result carries four motor pulses and the arming
// flags. A request is registered, decoded and mixed from the input register,
// and the result is registered in the output register; a new request is taken
// every cycle while the result side keeps up. The armed flag is updated as
// each request leaves the input register, in arrival order. Configuration
// writes take effect at once and must only be made with the unit empty.
module quad_arming_and_motor_mixer_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // throttle_width, roll_width, pitch_width, yaw_width,
    // roll_correction, pitch_correction, yaw_correction, zero fill
    input  logic [qamm_pkg::IN_TDW-1:0]  i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // front_right_pulse, back_right_pulse, back_left_pulse, front_left_pulse,
    // armed_now, recalibrate_request, controller_reset_request, zero fill
    output logic [qamm_pkg::OUT_TDW-1:0] o_m_axis_tdata,
    input  logic                         i_cfg_we,
    input  logic [qamm_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [qamm_pkg::CFG_DW-1:0]  i_cfg_wdata
);
    import qamm_pkg::*;

    t_cfg        cfg;
    t_in_item    r_in;
    logic        r_in_valid;
    t_out_item   r_out, n_out;
    logic        r_out_valid;
    logic        r_armed;
    t_arm_status arm;
    logic        out_load, in_load;

    qamm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    qamm_arming u_arm (
        .i_armed      (r_armed),
        .i_throttle_w (r_in.throttle_w),
        .i_roll_w     (r_in.roll_w),
        .i_pitch_w    (r_in.pitch_w),
        .i_yaw_w      (r_in.yaw_w),
        .i_stick_low  (cfg.stick_low),
        .i_stick_high (cfg.stick_high),
        .o_status     (arm)
    );

    qamm_mixer u_mix (
        .i_spin        (arm.spin),
        .i_throttle_w  (r_in.throttle_w),
        .i_roll_corr   (r_in.roll_corr),
        .i_pitch_corr  (r_in.pitch_corr),
        .i_yaw_corr    (r_in.yaw_corr),
        .i_cfg         (cfg),
        .o_front_right (n_out.front_right),
        .o_back_right  (n_out.back_right),
        .o_back_left   (n_out.back_left),
        .o_front_left  (n_out.front_left)
    );

    assign n_out.pad       = '0;
    assign n_out.armed_now = arm.armed_next;
    assign n_out.recal     = arm.recal;
    assign n_out.ctl_reset = arm.ctl_reset;

    assign out_load        = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign in_load         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_in_valid || out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_armed     <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= 1'b1;
            end else if (out_load) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_armed     <= arm.armed_next;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in <= t_in_item'(i_s_axis_tdata);
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    a_armed_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_load |=> $stable(r_armed))
        else $error("armed flag changed without a request leaving the input register");

    a_armed_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out.armed_now == r_armed))
        else $error("reported armed flag differs from held state");

    a_reset_needs_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.ctl_reset |-> r_out.armed_now)
        else $error("controller reset requested while disarmed");

    a_off_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.armed_now |->
            (r_out.front_right == {1'b0, cfg.off_pulse}) &&
            (r_out.back_left == {1'b0, cfg.off_pulse}))
        else $error("motor pulse not off while disarmed");

    a_pulse_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.armed_now && !r_out.ctl_reset |->
            (r_out.front_right <= cfg.max_pulse) && (r_out.front_left <= cfg.max_pulse))
        else $error("motor pulse above upper limit");

endmodule
